// ===== rtl/jzpi_pkg.sv =====
// Package for the zero polynomial iterator: widths, result codes, state type
// and the controller/datapath command and status structs. No dependencies.
package jzpi_pkg;

    localparam int MaxZeros  = 10;
    localparam int DataWidth = 24;
    localparam int FracBits  = 20;
    localparam int IterWidth = 12;
    localparam int IdxWidth  = 4;
    localparam int LimWidth  = DataWidth - 1;
    localparam int CfgWidth  = DataWidth;
    localparam int MagWidth  = 2 * DataWidth;

    localparam logic [1:0] CFG_ZERO_COUNT = 2'd0;
    localparam logic [1:0] CFG_ESC_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;
    localparam logic [1:0] CFG_AMPLITUDE  = 2'd3;

    localparam logic [1:0] KIND_BOUNDED = 2'd0;
    localparam logic [1:0] KIND_ESCAPED = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ITER_START,
        ST_DIFF,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_FACTOR_DONE,
        ST_MAG,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_pixel;
        logic init_w;
        logic diff;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic mag;
        logic accept_w;
        logic set_escaped;
    } dp_cmd_t;

    typedef struct packed {
        logic start_gt;
        logic start_lt;
        logic w_ok;
    } dp_status_t;

endpackage

// ===== rtl/jzpi_datapath.sv =====
// Datapath of the zero polynomial iterator: zero table, signed factor
// multipliers, saturation and squared magnitude compare. Uses jzpi_pkg.
module jzpi_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  jzpi_pkg::dp_cmd_t                     cmd,
    input  logic                                  tbl_we,
    input  logic [jzpi_pkg::IdxWidth-1:0]         tbl_widx,
    input  logic signed [jzpi_pkg::DataWidth-1:0] tbl_wre,
    input  logic signed [jzpi_pkg::DataWidth-1:0] tbl_wim,
    input  logic [jzpi_pkg::IdxWidth-1:0]         tbl_ridx,
    input  logic signed [jzpi_pkg::DataWidth-1:0] pix_re,
    input  logic signed [jzpi_pkg::DataWidth-1:0] pix_im,
    input  logic [jzpi_pkg::LimWidth-1:0]         esc_limit,
    input  logic signed [jzpi_pkg::DataWidth-1:0] amp,
    output jzpi_pkg::dp_status_t                  status,
    output logic signed [jzpi_pkg::DataWidth-1:0] z_re,
    output logic signed [jzpi_pkg::DataWidth-1:0] z_im
);
    import jzpi_pkg::*;

    localparam int PW = 2 * DataWidth;
    localparam int SW = PW + 1;
    localparam logic signed [DataWidth-1:0] DMax = {1'b0, {(DataWidth-1){1'b1}}};
    localparam logic signed [DataWidth-1:0] DMin = {1'b1, {(DataWidth-1){1'b0}}};

    logic signed [DataWidth-1:0] tre_reg [MaxZeros];
    logic signed [DataWidth-1:0] tim_reg [MaxZeros];
    logic signed [DataWidth-1:0] zr_reg, zi_reg, wr_reg, wi_reg, dr_reg, di_reg;
    logic signed [PW-1:0]        p0_reg, p1_reg, p2_reg, p3_reg;
    logic                        flag_reg;
    logic [MagWidth:0]           mag_reg;
    logic [MagWidth:0]           start_mag;
    logic [MagWidth-1:0]         lim2;

    function automatic logic signed [DataWidth-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > $signed({{(SW-DataWidth){1'b0}}, DMax})) return DMax;
        if (v < $signed({{(SW-DataWidth){1'b1}}, DMin})) return DMin;
        return v[DataWidth-1:0];
    endfunction

    function automatic logic ovf(input logic signed [SW-1:0] v);
        return (v > $signed({{(SW-DataWidth){1'b0}}, DMax}))
            || (v < $signed({{(SW-DataWidth){1'b1}}, DMin}));
    endfunction

    function automatic logic [MagWidth:0] mag2(input logic signed [DataWidth-1:0] a,
                                               input logic signed [DataWidth-1:0] b);
        logic [DataWidth-1:0] ua, ub;
        ua = a[DataWidth-1] ? DataWidth'(-a) : a;
        ub = b[DataWidth-1] ? DataWidth'(-b) : b;
        return (MagWidth+1)'(ua * ua) + (MagWidth+1)'(ub * ub);
    endfunction

    logic signed [DataWidth:0] ddr, ddi;
    logic signed [SW-1:0]      sre, sim, shre, shim;
    logic signed [DataWidth-1:0] mul_x, mul_y;
    logic signed [PW-1:0]        mul_p;

    assign lim2      = MagWidth'(esc_limit) * MagWidth'(esc_limit);
    assign start_mag = mag2(zr_reg, zi_reg);
    assign ddr = {zr_reg[DataWidth-1], zr_reg}
               - {tre_reg[tbl_ridx][DataWidth-1], tre_reg[tbl_ridx]};
    assign ddi = {zi_reg[DataWidth-1], zi_reg}
               - {tim_reg[tbl_ridx][DataWidth-1], tim_reg[tbl_ridx]};
    assign sre  = {p0_reg[PW-1], p0_reg} - {p1_reg[PW-1], p1_reg};
    assign sim  = {p2_reg[PW-1], p2_reg} + {p3_reg[PW-1], p3_reg};
    assign shre = sre >>> FracBits;
    assign shim = sim >>> FracBits;
    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        mul_x = cmd.mul_a ? wr_reg : wi_reg;
        mul_y = cmd.mul_a ? dr_reg : di_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxZeros; i++)
            begin
                tre_reg[i] <= '0;
                tim_reg[i] <= '0;
            end
        end
        else if (tbl_we && (32'(tbl_widx) < MaxZeros))
        begin
            tre_reg[tbl_widx] <= tbl_wre;
            tim_reg[tbl_widx] <= tbl_wim;
        end
    end

    // Each factor forms the products with wr first, then those with wi.
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            zr_reg <= pix_re;
            zi_reg <= pix_im;
        end
        if (cmd.init_w)
        begin
            wr_reg   <= amp;
            wi_reg   <= '0;
            flag_reg <= 1'b0;
        end
        if (cmd.diff)
        begin
            dr_reg <= sat_w({{(SW-DataWidth-1){ddr[DataWidth]}}, ddr});
            di_reg <= sat_w({{(SW-DataWidth-1){ddi[DataWidth]}}, ddi});
            if (ovf({{(SW-DataWidth-1){ddr[DataWidth]}}, ddr})
                || ovf({{(SW-DataWidth-1){ddi[DataWidth]}}, ddi}))
                flag_reg <= 1'b1;
        end
        if (cmd.mul_a)
        begin
            p0_reg <= mul_p;
            p3_reg <= wr_reg * di_reg;
        end
        if (cmd.mul_b)
        begin
            p1_reg <= mul_p;
            p2_reg <= wi_reg * dr_reg;
        end
        if (cmd.sum)
        begin
            wr_reg <= sat_w(shre);
            wi_reg <= sat_w(shim);
            if (ovf(shre) || ovf(shim))
                flag_reg <= 1'b1;
        end
        if (cmd.mag)
            mag_reg <= mag2(wr_reg, wi_reg);
        if (cmd.accept_w)
        begin
            zr_reg <= wr_reg;
            zi_reg <= wi_reg;
        end
    end

    assign status.start_gt = start_mag > (MagWidth+1)'(lim2);
    assign status.start_lt = start_mag < (MagWidth+1)'(lim2);
    assign status.w_ok     = !flag_reg && (mag_reg < (MagWidth+1)'(lim2));
    assign z_re = zr_reg;
    assign z_im = zi_reg;

endmodule

// ===== rtl/jzpi_controller.sv =====
// Controller of the zero polynomial iterator: sequences the iteration and
// the factor loop, and forms the result strobe. Uses jzpi_pkg.
module jzpi_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           pix_cmd,
    input  logic                           pix_valid,
    input  logic                           parity,
    input  logic [3:0]                     zero_cnt,
    input  logic [jzpi_pkg::IterWidth-1:0] iter_limit,
    input  jzpi_pkg::dp_status_t           status,
    output jzpi_pkg::dp_cmd_t              cmd,
    output logic [jzpi_pkg::IdxWidth-1:0]  tbl_ridx,
    output logic                           busy,
    output logic                           done,
    output logic [1:0]                     kind,
    output logic                           parity_q
);
    import jzpi_pkg::*;

    state_t               state_reg, state_next;
    logic [IterWidth-1:0] it_reg, it_next;
    logic [IdxWidth-1:0]  k_reg, k_next;
    logic [IterWidth-1:0] ilim_reg, ilim_next;
    logic [IdxWidth-1:0]  n_reg, n_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 par_reg, par_next;
    logic [IdxWidth-1:0]  n_sat;

    assign n_sat = (32'(zero_cnt) > MaxZeros) ? IdxWidth'(MaxZeros) : IdxWidth'(zero_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            it_reg    <= '0;
            k_reg     <= '0;
            ilim_reg  <= '0;
            n_reg     <= '0;
            kind_reg  <= KIND_BOUNDED;
            par_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
            k_reg     <= k_next;
            ilim_reg  <= ilim_next;
            n_reg     <= n_next;
            kind_reg  <= kind_next;
            par_reg   <= par_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        k_next     = k_reg;
        ilim_next  = ilim_reg;
        n_next     = n_reg;
        kind_next  = kind_reg;
        par_next   = par_reg;
        cmd        = '0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && pix_cmd)
                begin
                    cmd.load_pixel = 1'b1;
                    ilim_next = iter_limit;
                    n_next    = n_sat;
                    par_next  = parity;
                    kind_next = KIND_BOUNDED;
                    it_next   = '0;
                    if (pix_valid)
                        state_next = ST_CHECK;
                    else
                    begin
                        kind_next  = KIND_INVALID;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.start_gt)
                begin
                    kind_next  = KIND_ESCAPED;
                    state_next = ST_DONE;
                end
                else if (status.start_lt)
                    state_next = ST_ITER_START;
                else
                    state_next = ST_DONE;
            end
            ST_ITER_START:
            begin
                if (it_reg >= ilim_reg)
                    state_next = ST_DONE;
                else
                begin
                    cmd.init_w = 1'b1;
                    k_next = n_reg;
                    state_next = (n_reg == '0) ? ST_MAG : ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                k_next     = k_reg - 1'b1;
                state_next = ST_FACTOR_DONE;
            end
            ST_FACTOR_DONE:
            begin
                state_next = (k_reg == '0) ? ST_MAG : ST_DIFF;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.w_ok)
                begin
                    cmd.accept_w = 1'b1;
                    it_next      = it_reg + 1'b1;
                    state_next   = ST_ITER_START;
                end
                else
                begin
                    kind_next  = KIND_ESCAPED;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign tbl_ridx = k_reg - 1'b1;
    assign busy     = (state_reg != ST_IDLE);
    assign kind     = kind_reg;
    assign parity_q = par_reg && (kind_reg == KIND_BOUNDED);

    a_done_from_idle_never: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == ST_IDLE) else $error("result strobe not followed by idle");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIFF |-> it_reg < ilim_reg) else $error("iteration past limit");
    a_factor_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIFF |-> (k_reg != '0 && k_reg <= n_reg))
        else $error("factor index out of range");
    a_single_mul: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_a && cmd.mul_b)) else $error("multiplier used twice");

endmodule

// ===== rtl/julia_zero_polynomial_iterator_unit.sv =====
// Top level of the zero polynomial iterator: configuration registers and
// the controller and datapath instances. Uses jzpi_pkg.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// cmd 0 writes zero_re/zero_im into table entry zero_index in that cycle
// and returns nothing; busy stays low. cmd 1 processes a pixel and raises
// busy until the result, which appears for exactly one cycle with
// result_valid high; the receiver cannot stall it.
// A pixel steps through the controller states: an invalid one goes straight
// to the result; else ST_CHECK ends it when the start point is on or beyond
// the limit. Each iteration runs ST_ITER_START, then for each of the n zeros
// ST_DIFF, ST_MUL_A, ST_MUL_B, ST_SUM and ST_FACTOR_DONE, then ST_MAG and
// ST_DECIDE. The next item can be taken in the cycle after the result.
// Defaults: n = 1, iteration limit 100. Configuration is written through
// cfg_we, cfg_index, cfg_data while idle; the user keeps to this, the block
// does not enforce it. Reset clears the zero table and loads the defaults.
module julia_zero_polynomial_iterator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [jzpi_pkg::CfgWidth-1:0]         cfg_data,
    input  logic                                  cmd,
    input  logic [jzpi_pkg::IdxWidth-1:0]         zero_index,
    input  logic signed [jzpi_pkg::DataWidth-1:0] zero_re,
    input  logic signed [jzpi_pkg::DataWidth-1:0] zero_im,
    input  logic signed [jzpi_pkg::DataWidth-1:0] pixel_re,
    input  logic signed [jzpi_pkg::DataWidth-1:0] pixel_im,
    input  logic                                  pixel_valid,
    input  logic                                  parity_in,
    output logic                                  result_valid,
    output logic signed [jzpi_pkg::DataWidth-1:0] out_re,
    output logic signed [jzpi_pkg::DataWidth-1:0] out_im,
    output logic [1:0]                            result_kind,
    output logic                                  parity_out
);
    import jzpi_pkg::*;

    logic [3:0]           zcnt_reg;
    logic [LimWidth-1:0]  elim_reg;
    logic [IterWidth-1:0] ilim_reg;
    logic signed [DataWidth-1:0] amp_reg;
    dp_cmd_t              dcmd;
    dp_status_t           dstat;
    logic [IdxWidth-1:0]  ridx;
    logic signed [DataWidth-1:0] zr, zi;
    logic [1:0]           kind;
    logic                 par;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zcnt_reg <= 4'd1;
            elim_reg <= LimWidth'(2097152);
            ilim_reg <= IterWidth'(100);
            amp_reg  <= DataWidth'(1048576);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZERO_COUNT: zcnt_reg <= cfg_data[3:0];
                CFG_ESC_LIMIT:  elim_reg <= cfg_data[LimWidth-1:0];
                CFG_ITER_LIMIT: ilim_reg <= cfg_data[IterWidth-1:0];
                CFG_AMPLITUDE:  amp_reg  <= cfg_data[DataWidth-1:0];
                default: ;
            endcase
        end
    end

    jzpi_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pix_cmd    (cmd),
        .pix_valid  (pixel_valid),
        .parity     (parity_in),
        .zero_cnt   (zcnt_reg),
        .iter_limit (ilim_reg),
        .status     (dstat),
        .cmd        (dcmd),
        .tbl_ridx   (ridx),
        .busy       (busy),
        .done       (result_valid),
        .kind       (kind),
        .parity_q   (par)
    );

    jzpi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dcmd),
        .tbl_we    (start && !busy && !cmd),
        .tbl_widx  (zero_index),
        .tbl_wre   (zero_re),
        .tbl_wim   (zero_im),
        .tbl_ridx  (ridx),
        .pix_re    (pixel_re),
        .pix_im    (pixel_im),
        .esc_limit (elim_reg),
        .amp       (amp_reg),
        .status    (dstat),
        .z_re      (zr),
        .z_im      (zi)
    );

    assign result_kind = kind;
    assign parity_out  = par;
    assign out_re      = (kind == KIND_INVALID) ? '0 : zr;
    assign out_im      = (kind == KIND_INVALID) ? '0 : zi;

endmodule

// ===== tb/sv/jzpi_checker.sv =====
`timescale 1ns / 100ps
// Checker for the zero polynomial iterator: watches the command, configuration
// and result channels, predicts each pixel result and compares it. Uses jzpi_pkg.
module jzpi_checker
    import jzpi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [CfgWidth-1:0]         cfg_data,
    input  logic                        cmd,
    input  logic [IdxWidth-1:0]         zero_index,
    input  logic signed [DataWidth-1:0] zero_re,
    input  logic signed [DataWidth-1:0] zero_im,
    input  logic signed [DataWidth-1:0] pixel_re,
    input  logic signed [DataWidth-1:0] pixel_im,
    input  logic                        pixel_valid,
    input  logic                        parity_in,
    input  logic                        result_valid,
    input  logic signed [DataWidth-1:0] out_re,
    input  logic signed [DataWidth-1:0] out_im,
    input  logic [1:0]                  result_kind,
    input  logic                        parity_out,
    output int                          fail_count,
    output int                          outstanding
);

    typedef struct packed {
        logic signed [DataWidth-1:0] re;
        logic signed [DataWidth-1:0] im;
        logic [1:0]                  kind;
        logic                        parity;
    } pixel_result_t;

    pixel_result_t               expected_points[$];
    logic signed [DataWidth-1:0] roots_re[MaxZeros];
    logic signed [DataWidth-1:0] roots_im[MaxZeros];
    logic [IdxWidth-1:0]         num_roots;
    logic [LimWidth-1:0]         radius;
    logic [IterWidth-1:0]        max_iters;
    logic signed [DataWidth-1:0] gain;

    function automatic longint clamp(longint v, inout bit ovf);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DataWidth - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic pixel_result_t iterate_pixel(longint zr, longint zi, logic par);
        pixel_result_t r;
        longint wr, wi, dr, di, nr, ni, lim2, m;
        int n;
        bit ovf;
        bit esc;
        esc = 1'b0;
        lim2 = longint'(radius) * longint'(radius);
        n = (num_roots > MaxZeros) ? MaxZeros : int'(num_roots);
        m = zr * zr + zi * zi;
        if (m > lim2) begin
            esc = 1'b1;
        end else if (m < lim2) begin
            for (int it = 0; it < int'(max_iters); it++) begin
                ovf = 1'b0;
                wr = longint'(gain);
                wi = 0;
                for (int k = n - 1; k >= 0; k--) begin
                    dr = clamp(zr - longint'(roots_re[k]), ovf);
                    di = clamp(zi - longint'(roots_im[k]), ovf);
                    nr = clamp((wr * dr - wi * di) >>> FracBits, ovf);
                    ni = clamp((wr * di + wi * dr) >>> FracBits, ovf);
                    wr = nr;
                    wi = ni;
                end
                if (!ovf && (wr * wr + wi * wi) < lim2) begin
                    zr = wr;
                    zi = wi;
                end else begin
                    esc = 1'b1;
                    break;
                end
            end
        end
        r.re = zr[DataWidth-1:0];
        r.im = zi[DataWidth-1:0];
        r.kind = esc ? KIND_ESCAPED : KIND_BOUNDED;
        r.parity = !esc && par;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_result_t p;
        if (!rst_n) begin
            for (int k = 0; k < MaxZeros; k++) begin
                roots_re[k] = '0;
                roots_im[k] = '0;
            end
            num_roots = 1;
            radius = 23'd2097152;
            max_iters = 12'd100;
            gain = 24'sd1048576;
            expected_points.delete();
            fail_count <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ZERO_COUNT: num_roots = cfg_data[IdxWidth-1:0];
                    CFG_ESC_LIMIT:  radius = cfg_data[LimWidth-1:0];
                    CFG_ITER_LIMIT: max_iters = cfg_data[IterWidth-1:0];
                    CFG_AMPLITUDE:  gain = cfg_data[DataWidth-1:0];
                    default: ;
                endcase
            end
            if (result_valid) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d kind=%0d parity=%0b",
                             $time, out_re, out_im, result_kind, parity_out);
                    fail_count <= fail_count + 1;
                end else begin
                    p = expected_points.pop_front();
                    if (out_re !== p.re || out_im !== p.im || result_kind !== p.kind
                        || parity_out !== p.parity) begin
                        $display("%0t: mismatch expected re=%0d im=%0d kind=%0d parity=%0b",
                                 $time, p.re, p.im, p.kind, p.parity);
                        $display("%0t:          actual   re=%0d im=%0d kind=%0d parity=%0b",
                                 $time, out_re, out_im, result_kind, parity_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (!cmd) begin
                    if (zero_index < MaxZeros) begin
                        roots_re[zero_index] = zero_re;
                        roots_im[zero_index] = zero_im;
                    end
                end else if (!pixel_valid) begin
                    p.re = '0;
                    p.im = '0;
                    p.kind = KIND_INVALID;
                    p.parity = 1'b0;
                    expected_points.push_back(p);
                end else begin
                    expected_points.push_back(iterate_pixel(longint'(pixel_re),
                                                            longint'(pixel_im), parity_in));
                end
            end
            outstanding <= expected_points.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the zero polynomial iterator: clock, reset, command
// and configuration stimulus, watchdog and verdict. Uses jzpi_pkg and jzpi_checker.
module tb_top;
    import jzpi_pkg::*;

    localparam int WatchdogLimit = 1000000;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [CfgWidth-1:0]         cfg_data;
    logic                        cmd;
    logic [IdxWidth-1:0]         zero_index;
    logic signed [DataWidth-1:0] zero_re;
    logic signed [DataWidth-1:0] zero_im;
    logic signed [DataWidth-1:0] pixel_re;
    logic signed [DataWidth-1:0] pixel_im;
    logic                        pixel_valid;
    logic                        parity_in;
    logic                        result_valid;
    logic signed [DataWidth-1:0] out_re;
    logic signed [DataWidth-1:0] out_im;
    logic [1:0]                  result_kind;
    logic                        parity_out;
    int                          fail_count;
    int                          outstanding;
    int                          idle_cycles = 0;

    julia_zero_polynomial_iterator_unit uut (.*);

    jzpi_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Waits for the transfer of the item already on the ports.
    task automatic await_transfer();
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic load_root(logic [IdxWidth-1:0] idx, logic [23:0] re, logic [23:0] im);
        cmd <= 1'b0;
        zero_index <= idx;
        zero_re <= re;
        zero_im <= im;
        pixel_re <= 24'($urandom);
        pixel_im <= 24'($urandom);
        pixel_valid <= 1'($urandom);
        parity_in <= 1'($urandom);
        await_transfer();
    endtask

    task automatic send_pixel(logic [23:0] re, logic [23:0] im, logic vld, logic par);
        cmd <= 1'b1;
        zero_index <= 4'($urandom);
        zero_re <= 24'($urandom);
        zero_im <= 24'($urandom);
        pixel_re <= re;
        pixel_im <= im;
        pixel_valid <= vld;
        parity_in <= par;
        await_transfer();
    endtask

    task automatic pause_sender();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        n = (sel < 55) ? 0 : (sel < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] zc, logic [22:0] lim, logic [11:0] its,
                              logic [23:0] amp);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_ZERO_COUNT;
        cfg_data <= 24'(zc);
        @(posedge clk);
        cfg_index <= CFG_ESC_LIMIT;
        cfg_data <= 24'(lim);
        @(posedge clk);
        cfg_index <= CFG_ITER_LIMIT;
        cfg_data <= 24'(its);
        @(posedge clk);
        cfg_index <= CFG_AMPLITUDE;
        cfg_data <= amp;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] coord(int spread);
        if ($urandom_range(0, 99) < 25) return 24'($urandom);
        return 24'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                load_root(4'($urandom_range(0, 15)), coord(1048576), coord(1048576));
            end
            else
            begin
                send_pixel(coord(1572864), coord(1572864), $urandom_range(0, 99) < 90,
                           1'($urandom));
            end
            pause_sender();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd = 1'b0;
        zero_index = '0;
        zero_re = '0;
        zero_im = '0;
        pixel_re = '0;
        pixel_im = '0;
        pixel_valid = 1'b0;
        parity_in = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers with the cleared table.
        send_pixel(24'sd0, 24'sd0, 1'b0, 1'b1);
        send_pixel(24'sd524288, -24'sd262144, 1'b1, 1'b1);
        send_pixel(24'sd2097152, 24'sd0, 1'b1, 1'b1);
        send_pixel(24'sh7FFFFF, 24'sh800000, 1'b1, 1'b1);
        send_pixel(24'sh800000, 24'sh7FFFFF, 1'b1, 1'b0);
        load_root(4'd15, 24'sh7FFFFF, 24'sh800000);
        load_root(4'd10, 24'sh800000, 24'sh7FFFFF);
        load_root(4'd9, 24'sh7FFFFF, 24'sh800000);
        load_root(4'd0, -24'sd524288, 24'sd262144);
        send_pixel(24'sd300000, 24'sd100000, 1'b1, 1'b1);

        set_config(4'd0, 23'h7FFFFF, 12'd3, 24'sh800000);
        send_pixel(24'sd0, 24'sd0, 1'b1, 1'b1);
        send_pixel(24'sd1048576, -24'sd1048576, 1'b1, 1'b0);

        set_config(4'd15, 23'd0, 12'd4095, 24'sh7FFFFF);
        send_pixel(24'sd0, 24'sd0, 1'b1, 1'b1);
        send_pixel(24'sd1, 24'sd0, 1'b1, 1'b1);
        send_pixel(24'sd0, 24'sd0, 1'b0, 1'b1);

        set_config(4'd10, 23'h7FFFFF, 12'd2, 24'sh7FFFFF);
        send_pixel(24'sd1048576, 24'sd1048576, 1'b1, 1'b1);
        send_pixel(-24'sd4000000, 24'sd4000000, 1'b1, 1'b1);

        set_config(4'd1, 23'd2097152, 12'd4095, 24'sd0);
        send_pixel(24'sd100000, -24'sd100000, 1'b1, 1'b1);
        send_pixel(24'sd0, 24'sd0, 1'b1, 1'b0);

        set_config(4'd1, 23'd2097152, 12'd0, 24'sd1048576);
        send_pixel(24'sd1048576, 24'sd0, 1'b1, 1'b1);
        send_pixel(24'sd3000000, 24'sd0, 1'b1, 1'b1);

        for (int ph = 0; ph < 26; ph++)
        begin
            set_config(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4)),
                       ($urandom_range(0, 4) == 0) ? 23'($urandom)
                                                   : 23'($urandom_range(1048576, 4194304)),
                       12'($urandom_range(0, 12)),
                       ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(524288, 1572864)));
            for (int k = 0; k < 10; k++)
            begin
                load_root(4'(k), coord(1048576), coord(1048576));
            end
            random_phase(10);
        end

        drain();
        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
